// ===== sv/itaf_pkg.sv =====
// Shared types, codes and sizing constants for the integer to ASCII formatter.
// No dependencies; every other file of the block imports this package.
package itaf_pkg;

  localparam int DIGIT_SLOTS = 22;
  localparam int MAX_WIDTH   = 63;
  localparam int BCD_DIGITS  = 20;
  localparam int IDX_W       = $clog2(DIGIT_SLOTS);
  localparam int SLOT_W      = $clog2(DIGIT_SLOTS + 1);

  localparam logic [SLOT_W-1:0] SLOTS_DEC16 = SLOT_W'(7);
  localparam logic [SLOT_W-1:0] SLOTS_DEC32 = SLOT_W'(12);
  localparam logic [SLOT_W-1:0] SLOTS_DEC64 = SLOT_W'(DIGIT_SLOTS);
  localparam logic [SLOT_W-1:0] SLOTS_HEX16 = SLOT_W'((DIGIT_SLOTS < 4) ? DIGIT_SLOTS : 4);
  localparam logic [SLOT_W-1:0] SLOTS_HEX32 = SLOT_W'((DIGIT_SLOTS < 8) ? DIGIT_SLOTS : 8);
  localparam logic [SLOT_W-1:0] SLOTS_HEX64 = SLOT_W'((DIGIT_SLOTS < 16) ? DIGIT_SLOTS : 16);

  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_LHEX = 2'd2;
  localparam logic [1:0] OP_UHEX = 2'd3;

  localparam logic [1:0] SZ_16 = 2'd0;
  localparam logic [1:0] SZ_32 = 2'd1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  size;
    logic [1:0]  operation;
    logic [5:0]  field_width;
    logic [4:0]  frac_digits;
    logic        zero_fill;
    logic        left_justify;
    logic        show_plus;
  } num_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } chr_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CONV,
    PH_FILL,
    PH_SIZE,
    PH_SIGN,
    PH_PAD,
    PH_DIGITS,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    EM_SIGN,
    EM_PAD,
    EM_DIGIT,
    EM_TAIL
  } emit_kind_t;

  typedef struct packed {
    logic       load;
    logic       conv;
    logic       fill;
    logic       size;
    logic       emit;
    emit_kind_t kind;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic fill_done;
    logic dig_last;
    logic pad_last;
    logic pad_none;
    logic has_sign;
    logic zf;
    logic lj;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/integer_to_ascii_formatter_top.sv =====
// Top level of the integer to ASCII formatter: sequencer plus datapath.
// Depends on itaf_pkg, itaf_ctrl and itaf_dpath.
//
// Usage: the num channel takes one integer with its printf-style format
// (signed/unsigned decimal, lower/upper hex; 16, 32 or 64 bits; field width,
// inserted decimal point, zero fill, left justify, show plus). The chr
// channel returns the text one ASCII character per item, last_char set on
// the final character. Both channels use valid/stall; an item moves on a
// rising edge with valid high and stall low.
// Timing: num_stall rises the cycle after an item is taken and stays high
// until its last character sits in the output register. A number passes
// through conversion (decimal: one bit per cycle through the shift-add-3
// converter; hex: no shifting), slot fill over its digit slots (7/12/22
// decimal, 4/8/16 hex), one written per cycle, sizing, and emission of at
// most 63 characters, one per cycle while the output is not stalled.
// The next number is taken while the final character still waits in the
// output register.
// Reset: synchronous, clears the sequencer to idle and empties the output
// register. A stalled receiver freezes emission; the held character stays.
module integer_to_ascii_formatter_top import itaf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic num_valid,
  output logic num_stall,
  input  num_t num,
  output logic chr_valid,
  input  logic chr_stall,
  output chr_t chr
);

  cmd_t  cmd;
  stat_t st;

  // sequencer: phase machine, accepts a number only when idle
  itaf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_stall (num_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: conversion, digit slots, padding and the output register
  itaf_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .num       (num),
    .cmd       (cmd),
    .st        (st),
    .chr_valid (chr_valid),
    .chr       (chr),
    .chr_stall (chr_stall)
  );

endmodule

// ===== sv/itaf_ctrl.sv =====
// Sequencer of the formatter: conversion, slot fill, sizing and emit phases.
// Depends on itaf_pkg; drives the datapath through cmd_t and reads stat_t.
module itaf_ctrl import itaf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  num_valid,
  output logic  num_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  phase_t phase, phase_next;
  logic   tail_on;

  assign tail_on   = st.lj && !st.zf && !st.pad_none;
  assign num_stall = (phase != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (num_valid) phase_next = PH_CONV;
      end
      PH_CONV: begin
        if (st.conv_done) phase_next = PH_FILL;
      end
      PH_FILL: begin
        if (st.fill_done) phase_next = PH_SIZE;
      end
      PH_SIZE: begin
        if (!st.zf && !st.lj && !st.pad_none) phase_next = PH_PAD;
        else if (st.has_sign)                 phase_next = PH_SIGN;
        else if (st.zf && !st.pad_none)       phase_next = PH_PAD;
        else                                  phase_next = PH_DIGITS;
      end
      PH_SIGN: begin
        if (st.out_free) phase_next = (st.zf && !st.pad_none) ? PH_PAD : PH_DIGITS;
      end
      PH_PAD: begin
        if (st.out_free && st.pad_last) begin
          phase_next = (st.zf || !st.has_sign) ? PH_DIGITS : PH_SIGN;
        end
      end
      PH_DIGITS: begin
        if (st.out_free && st.dig_last) phase_next = tail_on ? PH_TAIL : PH_IDLE;
      end
      PH_TAIL: begin
        if (st.out_free && st.pad_last) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = EM_SIGN;
    case (phase)
      PH_IDLE:  cmd.load = num_valid;
      PH_CONV:  cmd.conv = 1'b1;
      PH_FILL:  cmd.fill = 1'b1;
      PH_SIZE:  cmd.size = 1'b1;
      PH_SIGN: begin
        cmd.emit = st.out_free;
        cmd.kind = EM_SIGN;
      end
      PH_PAD: begin
        cmd.emit = st.out_free;
        cmd.kind = EM_PAD;
      end
      PH_DIGITS: begin
        cmd.emit = st.out_free;
        cmd.kind = EM_DIGIT;
        cmd.last = st.dig_last && !tail_on;
      end
      PH_TAIL: begin
        cmd.emit = st.out_free;
        cmd.kind = EM_TAIL;
        cmd.last = st.pad_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/itaf_dpath.sv =====
// Datapath of the formatter: operand capture, shift-add-3 BCD conversion,
// digit slot store, padding counters and the output register. Uses itaf_pkg.
module itaf_dpath import itaf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  num_t  num,
  input  cmd_t  cmd,
  output stat_t st,
  output logic  chr_valid,
  output chr_t  chr,
  input  logic  chr_stall
);

  logic [63:0]       val;
  logic [3:0]        bcd [BCD_DIGITS];
  logic [3:0]        adj [BCD_DIGITS];
  logic [6:0]        bitcnt;
  logic [7:0]        store [DIGIT_SLOTS];
  logic [IDX_W-1:0]  idx, start;
  logic [SLOT_W-1:0] slots, ptpos;
  logic [4:0]        prec;
  logic [5:0]        fw, padcnt;
  logic [7:0]        sign_char;
  logic              lead, point_en, is_dec, upper, has_sign, zf, lj;

  // operand capture
  logic [63:0]       mask, vm, mag, aligned;
  logic              top, neg_in, dec_in, point_in;
  logic [SLOT_W-1:0] slots_in;
  logic [6:0]        nbits_in;

  always_comb begin
    case (num.size)
      SZ_16: begin
        mask     = 64'h0000_0000_0000_FFFF;
        top      = num.value[15];
        nbits_in = 7'd16;
      end
      SZ_32: begin
        mask     = 64'h0000_0000_FFFF_FFFF;
        top      = num.value[31];
        nbits_in = 7'd32;
      end
      default: begin
        mask     = '1;
        top      = num.value[63];
        nbits_in = 7'd64;
      end
    endcase
    dec_in = (num.operation == OP_SDEC) || (num.operation == OP_UDEC);
    case (num.size)
      SZ_16:   slots_in = dec_in ? SLOTS_DEC16 : SLOTS_HEX16;
      SZ_32:   slots_in = dec_in ? SLOTS_DEC32 : SLOTS_HEX32;
      default: slots_in = dec_in ? SLOTS_DEC64 : SLOTS_HEX64;
    endcase
    vm     = num.value & mask;
    neg_in = (num.operation == OP_SDEC) && top;
    mag    = neg_in ? ((64'd0 - vm) & mask) : vm;
    case (num.size)
      SZ_16:   aligned = {mag[15:0], 48'd0};
      SZ_32:   aligned = {mag[31:0], 32'd0};
      default: aligned = mag;
    endcase
    point_in = dec_in && (num.frac_digits != 5'd0) &&
               ({1'b0, num.frac_digits} < 6'(slots_in));
  end

  // slot fill
  logic [SLOT_W-1:0] r, dsel;
  logic [3:0]        nib, dig;
  logic [7:0]        fill_char;
  logic              last_slot, strip_ok;

  always_comb begin
    r    = slots - SLOT_W'(1) - SLOT_W'(idx);
    dsel = (point_en && (6'(r) > {1'b0, prec})) ? r - SLOT_W'(1) : r;
    dig  = (6'(dsel) < 6'(BCD_DIGITS)) ? bcd[dsel] : 4'd0;
    nib  = val[{r[3:0], 2'b00} +: 4];
    if (is_dec) begin
      fill_char = (point_en && (SLOT_W'(idx) == ptpos)) ? CH_DOT : CH_ZERO + {4'd0, dig};
    end else if (nib < 4'd10) begin
      fill_char = CH_ZERO + {4'd0, nib};
    end else begin
      fill_char = (upper ? CH_UPPER : CH_LOWER) + {4'd0, nib - 4'd10};
    end
    last_slot = (SLOT_W'(idx) == slots - SLOT_W'(1));
    strip_ok  = lead && (fill_char == CH_ZERO) && !last_slot &&
                !(point_en && (SLOT_W'(idx) + SLOT_W'(1) == ptpos));
  end

  // sizing
  logic [SLOT_W-1:0] len;
  logic [5:0]        need, pad_calc;

  always_comb begin
    len      = slots - SLOT_W'(start);
    need     = 6'(len) + {5'd0, has_sign};
    pad_calc = (fw > need) ? fw - need : 6'd0;
  end

  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val       <= dec_in ? aligned : mag;
      bitcnt    <= dec_in ? nbits_in : 7'd0;
      for (int k = 0; k < BCD_DIGITS; k++) bcd[k] <= 4'd0;
      slots     <= slots_in;
      ptpos     <= slots_in - SLOT_W'(1) - SLOT_W'(num.frac_digits);
      prec      <= num.frac_digits;
      point_en  <= point_in;
      is_dec    <= dec_in;
      upper     <= (num.operation == OP_UHEX);
      has_sign  <= neg_in || num.show_plus;
      sign_char <= neg_in ? CH_MINUS : CH_PLUS;
      fw        <= (num.field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : num.field_width;
      zf        <= num.zero_fill;
      lj        <= num.left_justify;
      idx       <= '0;
      start     <= '0;
      lead      <= 1'b1;
    end
    // one bit per cycle into the BCD digits, add 3 ahead of each shift
    if (cmd.conv && (bitcnt != 7'd0)) begin
      bcd[0] <= {adj[0][2:0], val[63]};
      for (int k = 1; k < BCD_DIGITS; k++) bcd[k] <= {adj[k][2:0], adj[k-1][3]};
      val    <= {val[62:0], 1'b0};
      bitcnt <= bitcnt - 7'd1;
    end
    // one slot per cycle, most significant first; track the stripped prefix
    if (cmd.fill) begin
      store[idx] <= fill_char;
      idx        <= idx + IDX_W'(1);
      if (strip_ok) start <= idx + IDX_W'(1);
      else          lead  <= 1'b0;
    end
    if (cmd.size) begin
      padcnt <= pad_calc;
      idx    <= start;
    end
    if (cmd.emit) begin
      if (cmd.kind == EM_DIGIT) idx <= idx + IDX_W'(1);
      if ((cmd.kind == EM_PAD) || (cmd.kind == EM_TAIL)) padcnt <= padcnt - 6'd1;
    end
  end

  // output register; digit characters come straight from the slot store
  logic [7:0] emit_char;

  always_comb begin
    case (cmd.kind)
      EM_SIGN:  emit_char = sign_char;
      EM_PAD:   emit_char = zf ? CH_ZERO : CH_SPACE;
      EM_TAIL:  emit_char = CH_SPACE;
      default:  emit_char = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (cmd.emit) begin
      chr_valid <= 1'b1;
    end else if (!chr_stall) begin
      chr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      chr.out_char  <= (cmd.kind == EM_DIGIT) ? store[idx] : emit_char;
      chr.last_char <= cmd.last;
    end
  end

  always_comb begin
    st.conv_done = (bitcnt == 7'd0);
    st.fill_done = last_slot;
    st.dig_last  = last_slot;
    st.pad_last  = (padcnt == 6'd1);
    st.pad_none  = (pad_calc == 6'd0);
    st.has_sign  = has_sign;
    st.zf        = zf;
    st.lj        = lj;
    st.out_free  = !chr_valid || !chr_stall;
  end

endmodule

// ===== sv/itaf_check.sv =====
// Port-level checker for the formatter, bound to the top level.
// Depends on itaf_pkg for the payload types.
module itaf_check import itaf_pkg::*; (
  input logic clk,
  input logic rst,
  input logic num_valid,
  input logic num_stall,
  input num_t num,
  input logic chr_valid,
  input logic chr_stall,
  input chr_t chr
);

  // output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !chr_valid)
    else $error("chr_valid high after reset");

  // a taken number blocks the input until its text is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (num_valid && !num_stall) |=> num_stall)
    else $error("input not stalled after accept");

  // a fresh character only appears while a number is being rendered
  a_char_needs_work: assert property (@(posedge clk) disable iff (rst)
    $rose(chr_valid) |-> $past(num_stall))
    else $error("character produced while idle");

  // held character stays put under stall
  a_chr_hold: assert property (@(posedge clk) disable iff (rst)
    (chr_valid && chr_stall) |=> (chr_valid && $stable(chr)))
    else $error("stalled character changed");

endmodule

bind integer_to_ascii_formatter_top itaf_check u_check (.*);
